>>> hw/rtl/bpdc_pkg.sv
// Shared types and constants for the button press duration classifier.
`timescale 1ns / 1ps
package bpdc_pkg;

    localparam int REG_W      = 16;
    localparam int DATA_W     = 32;
    localparam int ADDR_W     = 4;

    localparam logic [1:0] REG_ENABLE   = 2'd0;
    localparam logic [1:0] REG_DEBOUNCE = 2'd1;
    localparam logic [1:0] REG_MEDIUM   = 2'd2;
    localparam logic [1:0] REG_LONG     = 2'd3;

    localparam logic [REG_W-1:0] DEBOUNCE_RST = 16'd100;
    localparam logic [REG_W-1:0] MEDIUM_RST   = 16'd2000;
    localparam logic [REG_W-1:0] LONG_RST     = 16'd5000;

    localparam logic [1:0] CLASS_NONE   = 2'd0;
    localparam logic [1:0] CLASS_QUICK  = 2'd1;
    localparam logic [1:0] CLASS_MEDIUM = 2'd2;
    localparam logic [1:0] CLASS_LONG   = 2'd3;

    typedef struct packed {
        logic             enable;
        logic [REG_W-1:0] debounce_ticks;
        logic [REG_W-1:0] medium_threshold;
        logic [REG_W-1:0] long_threshold;
    } cfg_t;

    typedef struct packed {
        logic [1:0] press_class;
        logic       busy_res;
    } result_t;

endpackage

>>> hw/rtl/bpdc_cfg.sv
// Configuration register bank behind the APB port.
`timescale 1ns / 1ps
module bpdc_cfg
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bpdc_pkg::ADDR_W-1:0] paddr,
    input  logic [bpdc_pkg::DATA_W-1:0] pwdata,
    output logic [bpdc_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output bpdc_pkg::cfg_t              cfg
);

    logic                       enable_reg;
    logic [bpdc_pkg::REG_W-1:0] debounce_reg;
    logic [bpdc_pkg::REG_W-1:0] medium_reg;
    logic [bpdc_pkg::REG_W-1:0] long_reg;
    logic                       wr_en;
    logic [1:0]                 reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_sel = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg   <= 1'b0;
            debounce_reg <= bpdc_pkg::DEBOUNCE_RST;
            medium_reg   <= bpdc_pkg::MEDIUM_RST;
            long_reg     <= bpdc_pkg::LONG_RST;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                bpdc_pkg::REG_ENABLE:   enable_reg   <= pwdata[0];
                bpdc_pkg::REG_DEBOUNCE: debounce_reg <= pwdata[bpdc_pkg::REG_W-1:0];
                bpdc_pkg::REG_MEDIUM:   medium_reg   <= pwdata[bpdc_pkg::REG_W-1:0];
                bpdc_pkg::REG_LONG:     long_reg     <= pwdata[bpdc_pkg::REG_W-1:0];
                default:                ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            bpdc_pkg::REG_ENABLE:   prdata = {{(bpdc_pkg::DATA_W-1){1'b0}}, enable_reg};
            bpdc_pkg::REG_DEBOUNCE: prdata = bpdc_pkg::DATA_W'(debounce_reg);
            bpdc_pkg::REG_MEDIUM:   prdata = bpdc_pkg::DATA_W'(medium_reg);
            bpdc_pkg::REG_LONG:     prdata = bpdc_pkg::DATA_W'(long_reg);
            default:                prdata = '0;
        endcase
    end

    assign cfg.enable           = enable_reg;
    assign cfg.debounce_ticks   = debounce_reg;
    assign cfg.medium_threshold = medium_reg;
    assign cfg.long_threshold   = long_reg;

endmodule

>>> hw/rtl/bpdc_core.sv
// Press cycle state, counters and classification for one sample per step.
`timescale 1ns / 1ps
module bpdc_core
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              level,
    input  bpdc_pkg::cfg_t    cfg,
    output bpdc_pkg::result_t result
);

    localparam int CMP_W = (COUNT_WIDTH > bpdc_pkg::REG_W) ? COUNT_WIDTH : bpdc_pkg::REG_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    logic                   prev_level_reg,  prev_level_next;
    logic                   armed_reg,       armed_next;
    logic                   pending_reg,     pending_next;
    logic                   started_reg,     started_next;
    logic [COUNT_WIDTH-1:0] since_high_reg,  since_high_next;
    logic [COUNT_WIDTH-1:0] duration_reg,    duration_next;

    logic                   arm;
    logic                   active;
    logic [COUNT_WIDTH-1:0] since_inc;
    logic [COUNT_WIDTH-1:0] duration_inc;
    logic [CMP_W-1:0]       since_cmp;
    logic [CMP_W-1:0]       duration_cmp;
    logic [1:0]             class_sel;

    assign arm          = cfg.enable & ~armed_reg & ~prev_level_reg & level;
    assign active       = armed_reg | arm;
    assign since_inc    = (since_high_reg == CNT_MAX) ? CNT_MAX : since_high_reg + 1'b1;
    assign duration_inc = (started_reg && duration_reg != CNT_MAX) ?
                          duration_reg + 1'b1 : duration_reg;
    assign since_cmp    = CMP_W'(since_inc);
    assign duration_cmp = CMP_W'(duration_inc);

    always_comb
    begin
        if (duration_cmp > CMP_W'(cfg.long_threshold))
            class_sel = bpdc_pkg::CLASS_LONG;
        else if (duration_cmp > CMP_W'(cfg.medium_threshold))
            class_sel = bpdc_pkg::CLASS_MEDIUM;
        else
            class_sel = bpdc_pkg::CLASS_QUICK;
    end

    always_comb
    begin
        prev_level_next    = level;
        armed_next         = active;
        pending_next       = pending_reg;
        started_next       = started_reg;
        since_high_next    = since_high_reg;
        duration_next      = duration_reg;
        result.press_class = bpdc_pkg::CLASS_NONE;
        if (active)
        begin
            duration_next = duration_inc;
            if (level)
            begin
                pending_next    = 1'b1;
                since_high_next = '0;
                if (!started_reg)
                begin
                    started_next  = 1'b1;
                    duration_next = '0;
                end
            end
            else if (pending_reg)
            begin
                since_high_next = since_inc;
                if (since_cmp > CMP_W'(cfg.debounce_ticks))
                begin
                    result.press_class = class_sel;
                    armed_next         = 1'b0;
                    pending_next       = 1'b0;
                    started_next       = 1'b0;
                    since_high_next    = '0;
                    duration_next      = '0;
                end
            end
        end
        result.busy_res = armed_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_level_reg <= 1'b0;
            armed_reg      <= 1'b0;
            pending_reg    <= 1'b0;
            started_reg    <= 1'b0;
            since_high_reg <= '0;
            duration_reg   <= '0;
        end
        else if (step)
        begin
            prev_level_reg <= prev_level_next;
            armed_reg      <= armed_next;
            pending_reg    <= pending_next;
            started_reg    <= started_next;
            since_high_reg <= since_high_next;
            duration_reg   <= duration_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_pending_armed: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg |-> armed_reg)
        else $error("release pending outside an armed cycle");

    a_started_armed: assert property (@(posedge clk) disable iff (!rst_n)
        started_reg |-> armed_reg)
        else $error("duration running outside an armed cycle");

    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !armed_reg |-> (since_high_reg == '0 && duration_reg == '0))
        else $error("counters not cleared while idle");

    a_arm_enable: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(armed_reg) |-> $past(cfg.enable) && $past(step) && $past(level))
        else $error("cycle armed without enable and a high sample");
`endif

endmodule

>>> hw/rtl/button_press_duration_classifier.sv
// Top level: sample input register, classifier core, result register, APB registers.
//
//   channel   dir   handshake                          payload
//   s_axis    in    s_tvalid / s_tready                s_tdata[0] button_level
//   m_axis    out   m_tvalid / m_tready                m_tdata[1:0] press_class, [2] busy_res
//   apb       in    psel & penable & pwrite & pready   paddr, pwdata, prdata
//
// One result per sample; an accepted sample waits in the input register and moves to the output register on a step.
// Throughput is one sample per cycle while m_tready stays high; the core updates its state on each step.
// rst_n clears the cycle state and both pipeline valids; registers return to defaults.
// A stalled m_tready holds the result; the input register then fills and s_tready drops.
`timescale 1ns / 1ps
module button_press_duration_classifier
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [0] button_level
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,   // [1:0] press_class, [2] busy_res
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bpdc_pkg::ADDR_W-1:0] paddr,
    input  logic [bpdc_pkg::DATA_W-1:0] pwdata,
    output logic [bpdc_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    bpdc_pkg::cfg_t    cfg;
    bpdc_pkg::result_t result;

    logic       in_valid_reg;
    logic       in_level_reg;
    logic       out_valid_reg;
    logic [1:0] out_class_reg;
    logic       out_busy_reg;
    logic       step;

    assign step     = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | step;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_busy_reg, out_class_reg};

    bpdc_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bpdc_core #(.COUNT_WIDTH(COUNT_WIDTH)) u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .level  (in_level_reg),
        .cfg    (cfg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (step)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_level_reg <= s_tdata[0];
        if (step)
        begin
            out_class_reg <= result.press_class;
            out_busy_reg  <= result.busy_res;
        end
    end

`ifndef NO_ASSERTIONS
    a_class_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_class_reg != bpdc_pkg::CLASS_NONE) |-> !out_busy_reg)
        else $error("completed press reported while still busy");

    a_step_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |-> !step)
        else $error("result register overwritten while stalled");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !step) |=> in_valid_reg && $stable(in_level_reg))
        else $error("pending sample lost while stalled");
`endif

endmodule

>>> bench/tb_button_press_duration_classifier.sv
// Testbench for the button press duration classifier: directed and random level streams checked per tick.
`timescale 1ns / 1ps
module tb_button_press_duration_classifier;

    typedef struct packed {
        logic level;
        logic burst;
    } tick_t;

    logic                          clk      = 1'b0;
    logic                          rst_n    = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [7:0]                    s_tdata  = '0;    // [0] button_level
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [7:0]                    m_tdata;          // [1:0] press_class, [2] busy_res
    logic                          psel     = 1'b0;
    logic                          penable  = 1'b0;
    logic                          pwrite   = 1'b0;
    logic [bpdc_pkg::ADDR_W-1:0]   paddr    = '0;
    logic [bpdc_pkg::DATA_W-1:0]   pwdata   = '0;
    logic [bpdc_pkg::DATA_W-1:0]   prdata;
    logic                          pready;

    tick_t                         level_queue[$];
    bpdc_pkg::result_t             pending_results[$];
    logic                          calm       = 1'b0;
    logic                          burst_mode = 1'b0;
    int                            queued     = 0;
    int                            mismatches = 0;

    bpdc_pkg::cfg_t                regs = '{enable: 1'b0,
                                            debounce_ticks: bpdc_pkg::DEBOUNCE_RST,
                                            medium_threshold: bpdc_pkg::MEDIUM_RST,
                                            long_threshold: bpdc_pkg::LONG_RST};
    logic                          prev_level   = 1'b0;
    logic                          in_press     = 1'b0;
    logic                          release_seen = 1'b0;
    logic [bpdc_pkg::REG_W-1:0]    quiet_ticks  = '0;
    logic                          timing       = 1'b0;
    logic [bpdc_pkg::REG_W-1:0]    held_ticks   = '0;

    button_press_duration_classifier i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [bpdc_pkg::REG_W-1:0] bump(input logic [bpdc_pkg::REG_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic bpdc_pkg::result_t classify_tick(input logic level);
        bpdc_pkg::result_t r;
        r.press_class = bpdc_pkg::CLASS_NONE;
        if (regs.enable && !in_press && !prev_level && level)
            in_press = 1'b1;
        if (in_press)
        begin
            if (timing)
                held_ticks = bump(held_ticks);
            if (level)
            begin
                release_seen = 1'b1;
                quiet_ticks  = '0;
                if (!timing)
                begin
                    timing     = 1'b1;
                    held_ticks = '0;
                end
            end
            else if (release_seen)
            begin
                quiet_ticks = bump(quiet_ticks);
                if (quiet_ticks > regs.debounce_ticks)
                begin
                    if (held_ticks > regs.long_threshold)
                        r.press_class = bpdc_pkg::CLASS_LONG;
                    else if (held_ticks > regs.medium_threshold)
                        r.press_class = bpdc_pkg::CLASS_MEDIUM;
                    else
                        r.press_class = bpdc_pkg::CLASS_QUICK;
                    in_press     = 1'b0;
                    release_seen = 1'b0;
                    quiet_ticks  = '0;
                    timing       = 1'b0;
                    held_ticks   = '0;
                end
            end
        end
        prev_level = level;
        r.busy_res = in_press;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : drive_levels
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            calm     <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                pending_results.push_back(classify_tick(s_tdata[0]));
                void'(level_queue.pop_front());
            end
            if (!(s_tvalid && !s_tready))
            begin
                if (level_queue.size() != 0
                    && (level_queue[0].burst || $urandom_range(99) >= 25))
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {7'b0, level_queue[0].level};
                end
                else
                    s_tvalid <= 1'b0;
            end
            calm <= (level_queue.size() != 0) && level_queue[0].burst;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : check_results
        bpdc_pkg::result_t got;
        bpdc_pkg::result_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.press_class = m_tdata[1:0];
                got.busy_res    = m_tdata[2];
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result: press_class %0d, busy_res %0d",
                           got.press_class, got.busy_res);
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.press_class !== want.press_class)
                    begin
                        $error("press_class: expected %0d, got %0d",
                               want.press_class, got.press_class);
                        mismatches++;
                    end
                    if (got.busy_res !== want.busy_res)
                    begin
                        $error("busy_res: expected %0d, got %0d",
                               want.busy_res, got.busy_res);
                        mismatches++;
                    end
                end
            end
            m_tready <= calm || ($urandom_range(99) >= 25);
        end
    end

    task automatic add_levels(input logic level, input int count);
        tick_t t;
        t.level = level;
        t.burst = burst_mode;
        repeat (count)
        begin
            level_queue.push_back(t);
            queued++;
        end
    endtask

    // bouncy press: glitches stay within the debounce window, the final release exceeds it
    task automatic add_press(input int deb);
        int segments;
        segments = $urandom_range(1, 3);
        for (int k = 0; k < segments; k++)
        begin
            add_levels(1'b1, $urandom_range(1, 30));
            if (k < segments - 1 && deb > 0)
                add_levels(1'b0, $urandom_range(1, deb));
        end
        add_levels(1'b0, deb + 1 + $urandom_range(0, 4));
    endtask

    task automatic wait_drained();
        while (level_queue.size() != 0 || pending_results.size() != 0 || s_tvalid)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [bpdc_pkg::DATA_W-1:0] value);
        logic [bpdc_pkg::DATA_W-1:0] stored;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            bpdc_pkg::REG_ENABLE:
            begin
                regs.enable = value[0];
                stored      = {31'b0, value[0]};
            end
            bpdc_pkg::REG_DEBOUNCE:
            begin
                regs.debounce_ticks = value[bpdc_pkg::REG_W-1:0];
                stored              = {16'b0, value[bpdc_pkg::REG_W-1:0]};
            end
            bpdc_pkg::REG_MEDIUM:
            begin
                regs.medium_threshold = value[bpdc_pkg::REG_W-1:0];
                stored                = {16'b0, value[bpdc_pkg::REG_W-1:0]};
            end
            default:
            begin
                regs.long_threshold = value[bpdc_pkg::REG_W-1:0];
                stored              = {16'b0, value[bpdc_pkg::REG_W-1:0]};
            end
        endcase
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== stored)
        begin
            $error("register %0d readback: expected %0h, got %0h", idx, stored, prdata);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin : stimulus
        int          deb;
        int          start;
        logic [15:0] med;
        logic [15:0] lng;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // enable low: rising edge must not arm
        add_levels(1'b0, 1);
        add_levels(1'b1, 1);
        add_levels(1'b0, 1);
        wait_drained();
        write_reg(bpdc_pkg::REG_ENABLE, 32'h1);
        write_reg(bpdc_pkg::REG_DEBOUNCE, 32'hABCD_0000);
        write_reg(bpdc_pkg::REG_MEDIUM, 32'd1);
        write_reg(bpdc_pkg::REG_LONG, 32'd3);
        add_levels(1'b1, 1);
        add_levels(1'b0, 1);
        add_levels(1'b1, 3);
        add_levels(1'b0, 1);
        add_levels(1'b1, 5);
        add_levels(1'b0, 1);
        wait_drained();

        // drop enable mid-press: the press still completes
        write_reg(bpdc_pkg::REG_DEBOUNCE, 32'd3);
        add_levels(1'b1, 2);
        wait_drained();
        write_reg(bpdc_pkg::REG_ENABLE, 32'hFFFF_FFFE);
        add_levels(1'b0, 4);
        add_levels(1'b1, 1);
        add_levels(1'b0, 1);
        wait_drained();

        // hold the release with a maximal debounce, then release by lowering it
        write_reg(bpdc_pkg::REG_ENABLE, 32'h1);
        write_reg(bpdc_pkg::REG_DEBOUNCE, 32'h0000_FFFF);
        write_reg(bpdc_pkg::REG_MEDIUM, 32'd0);
        write_reg(bpdc_pkg::REG_LONG, 32'd65534);
        add_levels(1'b1, 40);
        add_levels(1'b0, 40);
        wait_drained();
        write_reg(bpdc_pkg::REG_DEBOUNCE, 32'd3);
        add_levels(1'b0, 2);
        wait_drained();

        for (int ph = 0; ph < 6; ph++)
        begin
            deb = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
            med = 16'($urandom_range(0, 60));
            lng = 16'($urandom_range(0, 80));
            if (ph == 0)
            begin
                med = 16'd0;
                lng = 16'd0;
            end
            else if (ph == 1)
            begin
                med = 16'hFFFF;
                lng = 16'hFFFF;
            end
            write_reg(bpdc_pkg::REG_ENABLE, ($urandom() & 32'hFFFF_FFFE)
                                  | (($urandom_range(6) != 0) ? 32'h1 : 32'h0));
            write_reg(bpdc_pkg::REG_DEBOUNCE, ($urandom() & 32'hFFFF_0000) | deb);
            write_reg(bpdc_pkg::REG_MEDIUM, ($urandom() & 32'hFFFF_0000) | med);
            write_reg(bpdc_pkg::REG_LONG, ($urandom() & 32'hFFFF_0000) | lng);
            burst_mode = (ph == 3);
            start = queued;
            while (queued - start < 285)
            begin
                if ($urandom_range(99) < 80)
                    add_press(deb);
                else
                    repeat ($urandom_range(1, 10))
                        add_levels(1'($urandom_range(0, 1)), 1);
            end
            wait_drained();
            burst_mode = 1'b0;
        end

        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin : watchdog
        #3_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/bpdc_pkg.sv
hw/rtl/bpdc_cfg.sv
hw/rtl/bpdc_core.sv
hw/rtl/button_press_duration_classifier.sv
bench/tb_button_press_duration_classifier.sv
